>>> src/bezier_curve_flattener_unit_macros.svh
// Assertion helpers for the curve flattener.
// Each check is clocked on clk and switched off while rst_n is low.
`ifndef BEZIER_CURVE_FLATTENER_UNIT_MACROS_SVH
`define BEZIER_CURVE_FLATTENER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bcf_pkg.sv
package bcf_pkg;

  // Coordinate and parameter formats
  localparam int COORD_BITS   = 24;
  localparam int SEG_BITS     = 6;
  localparam int MAX_SEGMENTS = 63;
  localparam int T_FRAC_BITS  = 16;
  localparam int T_W          = T_FRAC_BITS + 1;

  // Per-curve step divider: 2^(T+1) / (2n)
  localparam int DVD_W     = T_FRAC_BITS + 2;
  localparam int DVS_W     = SEG_BITS + 1;
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam logic [DVD_W-1:0] DIVIDEND = DVD_W'(1) << (T_FRAC_BITS + 1);

  // Interpolation datapath widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = DIFF_W + T_W + 1;
  localparam int RES_W  = PROD_W - T_FRAC_BITS;
  localparam logic signed [RES_W-1:0] RES_HI =
    RES_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [RES_W-1:0] RES_LO =
    RES_W'(-(64'sd1 <<< (COORD_BITS - 1)));
  localparam logic signed [PROD_W-1:0] ROUND_HALF =
    PROD_W'(64'sd1 <<< (T_FRAC_BITS - 1));

  // Issue counter: one interpolation on one axis per count
  localparam int OP_W = 4;
  localparam int QUAD_OPS  = 3;
  localparam int CUBIC_OPS = 6;
  localparam logic [OP_W-1:0] LAST_ISSUE_QUAD  = OP_W'(2 * QUAD_OPS - 1);
  localparam logic [OP_W-1:0] LAST_ISSUE_CUBIC = OP_W'(2 * CUBIC_OPS - 1);

  localparam logic KIND_QUAD  = 1'b0;
  localparam logic KIND_CUBIC = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [T_W-1:0]               tfrac_t;
  typedef logic [SEG_BITS-1:0]          seg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT,
    ST_END
  } bcf_state_t;

  // Operand / result slots of the de Casteljau network
  typedef enum logic [3:0] {
    NODE_P0,
    NODE_P1,
    NODE_P2,
    NODE_P3,
    NODE_A,
    NODE_B,
    NODE_D,
    NODE_E,
    NODE_F,
    NODE_C
  } bcf_node_t;

  typedef struct packed {
    bcf_node_t src_a;
    bcf_node_t src_b;
    bcf_node_t dst;
  } bcf_op_t;

  typedef struct packed {
    bcf_node_t dst;
    logic      axis;
  } lerp_tag_t;

  typedef struct packed {
    logic      valid;
    coord_t    a;
    coord_t    b;
    tfrac_t    t;
    lerp_tag_t tag;
  } lerp_req_t;

  typedef struct packed {
    logic      valid;
    coord_t    res;
    lerp_tag_t tag;
  } lerp_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    tfrac_t           quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  // Interpolation program, one entry per interpolation
  function automatic bcf_op_t bcf_prog(logic kind, logic [OP_W-2:0] idx);
    bcf_op_t op;
    op = '{src_a: NODE_P0, src_b: NODE_P1, dst: NODE_A};
    if (kind == KIND_CUBIC) begin
      case (idx)
        3'd0: op = '{src_a: NODE_P0, src_b: NODE_P1, dst: NODE_A};
        3'd1: op = '{src_a: NODE_P1, src_b: NODE_P2, dst: NODE_B};
        3'd2: op = '{src_a: NODE_P2, src_b: NODE_P3, dst: NODE_D};
        3'd3: op = '{src_a: NODE_A,  src_b: NODE_B,  dst: NODE_E};
        3'd4: op = '{src_a: NODE_B,  src_b: NODE_D,  dst: NODE_F};
        3'd5: op = '{src_a: NODE_E,  src_b: NODE_F,  dst: NODE_C};
        default: op = '{src_a: NODE_P0, src_b: NODE_P1, dst: NODE_A};
      endcase
    end else begin
      case (idx)
        3'd0: op = '{src_a: NODE_P0, src_b: NODE_P1, dst: NODE_A};
        3'd1: op = '{src_a: NODE_P1, src_b: NODE_P3, dst: NODE_B};
        3'd2: op = '{src_a: NODE_A,  src_b: NODE_B,  dst: NODE_C};
        default: op = '{src_a: NODE_P0, src_b: NODE_P1, dst: NODE_A};
      endcase
    end
    return op;
  endfunction

endpackage

>>> src/bcf_if.sv
// Curve input channel
interface bcf_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  bcf_pkg::coord_t   start_x;
  bcf_pkg::coord_t   start_y;
  bcf_pkg::coord_t   ctrl1_x;
  bcf_pkg::coord_t   ctrl1_y;
  bcf_pkg::coord_t   ctrl2_x;
  bcf_pkg::coord_t   ctrl2_y;
  bcf_pkg::coord_t   end_x;
  bcf_pkg::coord_t   end_y;
  bcf_pkg::seg_t     segment_count;

  modport source (
    output valid, kind, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
           end_x, end_y, segment_count,
    input  ready
  );
  modport sink (
    input  valid, kind, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
           end_x, end_y, segment_count,
    output ready
  );
endinterface

// Vertex output channel
interface bcf_out_if;
  logic            valid;
  logic            ready;
  bcf_pkg::coord_t vertex_x;
  bcf_pkg::coord_t vertex_y;
  logic            last;

  modport source (
    output valid, vertex_x, vertex_y, last,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, last,
    output ready
  );
endinterface

>>> src/bezier_curve_flattener_unit.sv
// Quadratic / cubic Bezier curve flattener.
// in_ch carries one curve per transfer: kind, start, ctrl1, ctrl2 (cubic only),
// end and a segment count n. out_ch returns n+1 vertices in order; vertex i
// below n is the curve at t = i/n (Q0.16, rounded), the last one is the end
// point itself with last set. A count of zero returns only the end point.
// Timing: one curve is worked at a time; in_ch.ready is high only while idle.
// After a transfer a divider derives the per-curve t step, then each
// vertex runs its interpolations through one shared multiply-add unit at one
// interpolation per cycle, x and y interleaved: 6 per vertex for quadratic,
// 12 for cubic, then a drain state and a state that loads the output register.
// Vertices leave through a single output register; when the receiver holds
// ready low the vertex stays there and the sequencer waits before loading the
// next one. Reset (rst_n low, synchronous) drops any curve in progress and
// clears the output valid.
`include "bezier_curve_flattener_unit_macros.svh"

module bezier_curve_flattener_unit (
  input  logic       clk,
  input  logic       rst_n,
  bcf_in_if.sink     in_ch,
  bcf_out_if.source  out_ch
);

  localparam int SEG_BITS     = bcf_pkg::SEG_BITS;
  localparam int MAX_SEGMENTS = bcf_pkg::MAX_SEGMENTS;
  localparam int T_FRAC_BITS  = bcf_pkg::T_FRAC_BITS;
  localparam int T_W          = bcf_pkg::T_W;
  localparam int DVS_W        = bcf_pkg::DVS_W;
  localparam int OP_W         = bcf_pkg::OP_W;

  bcf_pkg::bcf_state_t st_r, st_nxt;

  // Held curve
  bcf_pkg::coord_t p0_r [2];
  bcf_pkg::coord_t p1_r [2];
  bcf_pkg::coord_t p2_r [2];
  bcf_pkg::coord_t p3_r [2];
  logic            kind_r;
  bcf_pkg::seg_t   n_r;
  bcf_pkg::seg_t   n_in;

  // Intermediate interpolation results per axis
  bcf_pkg::coord_t a_r [2];
  bcf_pkg::coord_t b_r [2];
  bcf_pkg::coord_t d_r [2];
  bcf_pkg::coord_t e_r [2];
  bcf_pkg::coord_t f_r [2];
  bcf_pkg::coord_t c_r [2];

  // Vertex index and exact t as quotient / remainder of (2i*2^T + n) / 2n
  bcf_pkg::seg_t     vtx_r;
  bcf_pkg::tfrac_t   tq_r, tq_nxt;
  logic [DVS_W-1:0]  trem_r, trem_nxt;
  logic [DVS_W-1:0]  two_n;
  logic [DVS_W:0]    rsum;
  logic              rwrap;
  logic              vtx_final;

  logic [OP_W-1:0]   op_r;
  logic [OP_W-1:0]   last_issue;
  bcf_pkg::bcf_op_t  cur_op;
  logic              op_axis;

  logic              out_vld_r;
  bcf_pkg::coord_t   vx_r, vy_r;
  logic              last_r;

  logic              in_ready;
  logic              accept;
  logic              slot_free;
  logic              emit_ld;
  logic              end_ld;
  logic              issue_vld;

  bcf_pkg::div_req_t  div_req;
  bcf_pkg::div_rsp_t  div_rsp;
  bcf_pkg::lerp_req_t lerp_req;
  bcf_pkg::lerp_rsp_t lerp_rsp;

  // Read one node of the network for the given axis
  function automatic bcf_pkg::coord_t node_val(bcf_pkg::bcf_node_t nd, logic ax);
    bcf_pkg::coord_t v;
    case (nd)
      bcf_pkg::NODE_P0: v = p0_r[ax];
      bcf_pkg::NODE_P1: v = p1_r[ax];
      bcf_pkg::NODE_P2: v = p2_r[ax];
      bcf_pkg::NODE_P3: v = p3_r[ax];
      bcf_pkg::NODE_A:  v = a_r[ax];
      bcf_pkg::NODE_B:  v = b_r[ax];
      bcf_pkg::NODE_D:  v = d_r[ax];
      bcf_pkg::NODE_E:  v = e_r[ax];
      bcf_pkg::NODE_F:  v = f_r[ax];
      bcf_pkg::NODE_C:  v = c_r[ax];
      default:          v = p0_r[ax];
    endcase
    return v;
  endfunction

  // Saturate the incoming count
  assign n_in = (in_ch.segment_count > SEG_BITS'(MAX_SEGMENTS)) ?
                SEG_BITS'(MAX_SEGMENTS) : in_ch.segment_count;

  assign accept     = in_ready && in_ch.valid;
  assign slot_free  = !out_vld_r || out_ch.ready;
  assign last_issue = (kind_r == bcf_pkg::KIND_CUBIC) ?
                      bcf_pkg::LAST_ISSUE_CUBIC : bcf_pkg::LAST_ISSUE_QUAD;
  assign vtx_final  = (vtx_r + SEG_BITS'(1)) == n_r;
  assign two_n      = {n_r, 1'b0};

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      bcf_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          st_nxt = (n_in == '0) ? bcf_pkg::ST_END : bcf_pkg::ST_DIV;
        end
      end
      bcf_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          st_nxt = bcf_pkg::ST_ISSUE;
        end
      end
      bcf_pkg::ST_ISSUE: begin
        if (op_r == last_issue) begin
          st_nxt = bcf_pkg::ST_DRAIN;
        end
      end
      bcf_pkg::ST_DRAIN: st_nxt = bcf_pkg::ST_EMIT;
      bcf_pkg::ST_EMIT: begin
        if (slot_free) begin
          st_nxt = vtx_final ? bcf_pkg::ST_END : bcf_pkg::ST_ISSUE;
        end
      end
      bcf_pkg::ST_END: begin
        if (slot_free) begin
          st_nxt = bcf_pkg::ST_IDLE;
        end
      end
      default: st_nxt = bcf_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    issue_vld = 1'b0;
    emit_ld   = 1'b0;
    end_ld    = 1'b0;
    case (st_r)
      bcf_pkg::ST_IDLE:  in_ready  = 1'b1;
      bcf_pkg::ST_ISSUE: issue_vld = 1'b1;
      bcf_pkg::ST_EMIT:  emit_ld   = slot_free;
      bcf_pkg::ST_END:   end_ld    = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bcf_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Step divider, started on a transfer with a nonzero count
  assign div_req.start   = accept && (n_in != '0);
  assign div_req.divisor = {n_in, 1'b0};

  bcf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Issue one interpolation per cycle, x then y for each interpolation
  always_comb begin
    op_axis            = op_r[0];
    cur_op             = bcf_pkg::bcf_prog(kind_r, op_r[OP_W-1:1]);
    lerp_req.valid     = issue_vld;
    lerp_req.a         = node_val(cur_op.src_a, op_axis);
    lerp_req.b         = node_val(cur_op.src_b, op_axis);
    lerp_req.t         = tq_r;
    lerp_req.tag.dst   = cur_op.dst;
    lerp_req.tag.axis  = op_axis;
  end

  bcf_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (lerp_req),
    .rsp   (lerp_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= '0;
    end else if (issue_vld) begin
      op_r <= (op_r == last_issue) ? '0 : op_r + OP_W'(1);
    end
  end

  // Advance t by 1/n: add the step quotient, wrap the remainder at 2n
  always_comb begin
    rsum     = {1'b0, trem_r} + {1'b0, div_rsp.rem};
    rwrap    = rsum >= {1'b0, two_n};
    trem_nxt = rwrap ? DVS_W'(rsum - {1'b0, two_n}) : DVS_W'(rsum);
    tq_nxt   = tq_r + div_rsp.quot + T_W'(rwrap);
  end

  // Hold the curve and walk the vertices
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_ch.kind;
      n_r     <= n_in;
      p0_r[0] <= in_ch.start_x;
      p0_r[1] <= in_ch.start_y;
      p1_r[0] <= in_ch.ctrl1_x;
      p1_r[1] <= in_ch.ctrl1_y;
      p2_r[0] <= in_ch.ctrl2_x;
      p2_r[1] <= in_ch.ctrl2_y;
      p3_r[0] <= in_ch.end_x;
      p3_r[1] <= in_ch.end_y;
      vtx_r   <= '0;
      tq_r    <= '0;
      trem_r  <= DVS_W'(n_in);
    end else if (emit_ld && !vtx_final) begin
      vtx_r  <= vtx_r + SEG_BITS'(1);
      tq_r   <= tq_nxt;
      trem_r <= trem_nxt;
    end
  end

  // Write back interpolation results
  always_ff @(posedge clk) begin
    if (lerp_rsp.valid) begin
      case (lerp_rsp.tag.dst)
        bcf_pkg::NODE_A: a_r[lerp_rsp.tag.axis] <= lerp_rsp.res;
        bcf_pkg::NODE_B: b_r[lerp_rsp.tag.axis] <= lerp_rsp.res;
        bcf_pkg::NODE_D: d_r[lerp_rsp.tag.axis] <= lerp_rsp.res;
        bcf_pkg::NODE_E: e_r[lerp_rsp.tag.axis] <= lerp_rsp.res;
        bcf_pkg::NODE_F: f_r[lerp_rsp.tag.axis] <= lerp_rsp.res;
        bcf_pkg::NODE_C: c_r[lerp_rsp.tag.axis] <= lerp_rsp.res;
        default: ;
      endcase
    end
  end

  // Output register: load a vertex or the end point, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit_ld || end_ld) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ld) begin
      vx_r   <= c_r[0];
      vy_r   <= c_r[1];
      last_r <= 1'b0;
    end else if (end_ld) begin
      vx_r   <= p3_r[0];
      vy_r   <= p3_r[1];
      last_r <= 1'b1;
    end
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_vld_r;
  assign out_ch.vertex_x = vx_r;
  assign out_ch.vertex_y = vy_r;
  assign out_ch.last     = last_r;

  `BCF_ASSERT_NOW(a_t_below_one, st_r == bcf_pkg::ST_ISSUE, tq_r[T_FRAC_BITS] == 1'b0, "t reached one before the end point")
  `BCF_ASSERT_NOW(a_rem_bound, st_r == bcf_pkg::ST_ISSUE, trem_r < two_n, "t remainder not below 2n")
  `BCF_ASSERT_NOW(a_vtx_bound, st_r == bcf_pkg::ST_ISSUE, vtx_r < n_r, "vertex index past count")
  `BCF_ASSERT_NOW(a_lerp_window, lerp_rsp.valid, st_r == bcf_pkg::ST_ISSUE || st_r == bcf_pkg::ST_DRAIN, "interpolation result outside vertex work")
  `BCF_ASSERT_NEXT(a_end_to_idle, end_ld, st_r == bcf_pkg::ST_IDLE && out_vld_r && last_r, "end point not loaded with last")

endmodule

>>> src/bcf_div.sv
module bcf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bcf_pkg::div_req_t req,
  output bcf_pkg::div_rsp_t rsp
);

  localparam int DVD_W     = bcf_pkg::DVD_W;
  localparam int DVS_W     = bcf_pkg::DVS_W;
  localparam int DIV_CNT_W = bcf_pkg::DIV_CNT_W;
  localparam int T_W       = bcf_pkg::T_W;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r;
  logic [DVS_W:0]       shifted;
  logic                 fits;
  logic                 last_step;

  // One restoring step: shift in a dividend bit, subtract if it fits
  always_comb begin
    shifted   = {rem_r, quo_r[DVD_W-1]};
    fits      = shifted >= {1'b0, dvs_r};
    rem_nxt   = fits ? DVS_W'(shifted - {1'b0, dvs_r}) : DVS_W'(shifted);
    quo_nxt   = {quo_r[DVD_W-2:0], fits};
    last_step = busy_r && (cnt_r == DIV_CNT_W'(DVD_W - 1));
  end

  // Control: start, count steps, stop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
      if (last_step) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: load dividend, iterate
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= bcf_pkg::DIVIDEND;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = last_step;
  assign rsp.quot = quo_r[T_W-1:0];
  assign rsp.rem  = rem_r;

endmodule

>>> src/bcf_lerp.sv
module bcf_lerp (
  input  logic               clk,
  input  logic               rst_n,
  input  bcf_pkg::lerp_req_t req,
  output bcf_pkg::lerp_rsp_t rsp
);

  localparam int COORD_BITS  = bcf_pkg::COORD_BITS;
  localparam int T_FRAC_BITS = bcf_pkg::T_FRAC_BITS;
  localparam int T_W         = bcf_pkg::T_W;
  localparam int DIFF_W      = bcf_pkg::DIFF_W;
  localparam int PROD_W      = bcf_pkg::PROD_W;
  localparam int RES_W       = bcf_pkg::RES_W;

  logic signed [DIFF_W-1:0] diff;
  logic signed [T_W:0]      t_s;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] sum;
  logic signed [RES_W-1:0]  res;
  bcf_pkg::coord_t          a_r;
  bcf_pkg::lerp_tag_t       tag_r;
  logic                     vld_r;
  bcf_pkg::coord_t          res_sat;

  // Stage 1: (b - a) * t, since a*u + b*t == a*2^T + (b - a)*t
  always_comb begin
    diff     = DIFF_W'(req.b) - DIFF_W'(req.a);
    t_s      = signed'({1'b0, req.t});
    prod_nxt = diff * t_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    a_r    <= req.a;
    tag_r  <= req.tag;
  end

  // Stage 2: add a*2^T, round half up, floor shift, clamp
  always_comb begin
    sum = (PROD_W'(a_r) <<< T_FRAC_BITS) + prod_r + bcf_pkg::ROUND_HALF;
    res = RES_W'(sum >>> T_FRAC_BITS);
    if (res > bcf_pkg::RES_HI) begin
      res_sat = COORD_BITS'(bcf_pkg::RES_HI);
    end else if (res < bcf_pkg::RES_LO) begin
      res_sat = COORD_BITS'(bcf_pkg::RES_LO);
    end else begin
      res_sat = COORD_BITS'(res);
    end
  end

  assign rsp.valid = vld_r;
  assign rsp.res   = res_sat;
  assign rsp.tag   = tag_r;

endmodule

>>> sim/bcf_vertex_checker.sv
// Watches both channels of the curve flattener, works out the vertices of each
// accepted curve and compares every vertex transfer against the oldest one due.
module bcf_vertex_checker (
  input  logic clk,
  input  logic rst_n,
  bcf_in_if    in_ch,
  bcf_out_if   out_ch,
  output int   open_vertices,
  output int   mismatch_count
);
  import bcf_pkg::*;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } vertex_t;

  vertex_t vertex_due_q[$];
  int      errs = 0;

  // One de Casteljau step: a*(1-t) + b*t in Q0.16, round half up (floor of +0.5)
  function automatic longint lerp_q16(longint a, longint b, longint t);
    longint acc;
    acc = a * ((longint'(1) << T_FRAC_BITS) - t) + b * t
        + (longint'(1) << (T_FRAC_BITS - 1));
    return acc >>> T_FRAC_BITS;
  endfunction

  // Saturate to the signed coordinate range
  function automatic coord_t clamp_coord(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return coord_t'(hi);
    if (v < lo) return coord_t'(lo);
    return coord_t'(v);
  endfunction

  // Curve value on one axis; the quadratic form runs on start, ctrl1 and end
  function automatic coord_t curve_point(logic kind, longint p0, longint p1,
                                         longint p2, longint p3, longint t);
    longint a;
    longint b;
    longint d;
    if (kind == KIND_CUBIC) begin
      a = lerp_q16(p0, p1, t);
      b = lerp_q16(p1, p2, t);
      d = lerp_q16(p2, p3, t);
      return clamp_coord(lerp_q16(lerp_q16(a, b, t), lerp_q16(b, d, t), t));
    end
    a = lerp_q16(p0, p1, t);
    b = lerp_q16(p1, p3, t);
    return clamp_coord(lerp_q16(a, b, t));
  endfunction

  // Queue the n+1 vertices of the curve on the input channel
  task automatic queue_curve_vertices();
    int      n;
    longint  t;
    vertex_t v;
    n = int'(in_ch.segment_count);
    if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
    for (int i = 0; i < n; i++) begin
      t = (2 * longint'(i) * (longint'(1) << T_FRAC_BITS) + longint'(n))
        / (2 * longint'(n));
      v.x = curve_point(in_ch.kind, longint'(in_ch.start_x), longint'(in_ch.ctrl1_x),
                        longint'(in_ch.ctrl2_x), longint'(in_ch.end_x), t);
      v.y = curve_point(in_ch.kind, longint'(in_ch.start_y), longint'(in_ch.ctrl1_y),
                        longint'(in_ch.ctrl2_y), longint'(in_ch.end_y), t);
      v.last = 1'b0;
      vertex_due_q.push_back(v);
    end
    v.x    = in_ch.end_x;
    v.y    = in_ch.end_y;
    v.last = 1'b1;
    vertex_due_q.push_back(v);
  endtask

  // Compare vertex transfers, then add the vertices of a newly accepted curve
  always @(posedge clk) begin : watch
    vertex_t due;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (vertex_due_q.size() == 0) begin
          $error("unexpected vertex: vertex_x=%0d vertex_y=%0d last=%0b",
                 out_ch.vertex_x, out_ch.vertex_y, out_ch.last);
          errs++;
        end else begin
          due = vertex_due_q.pop_front();
          if (out_ch.vertex_x !== due.x) begin
            $error("vertex_x: expected %0d, got %0d", due.x, out_ch.vertex_x);
            errs++;
          end
          if (out_ch.vertex_y !== due.y) begin
            $error("vertex_y: expected %0d, got %0d", due.y, out_ch.vertex_y);
            errs++;
          end
          if (out_ch.last !== due.last) begin
            $error("last: expected %0b, got %0b", due.last, out_ch.last);
            errs++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) queue_curve_vertices();
    end
    open_vertices  <= vertex_due_q.size();
    mismatch_count <= errs;
  end

endmodule

>>> sim/tb_bezier_curve_flattener_unit.sv
module tb_bezier_curve_flattener_unit;
  import bcf_pkg::*;

  localparam int     RANDOM_CURVES = 416;
  localparam int     DRAIN_CYCLES  = 40;
  localparam coord_t COORD_MAX     = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN     = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct {
    logic   kind;
    coord_t pt[8];  // start, ctrl1, ctrl2, end; x then y
    seg_t   n;
  } curve_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   open_vertices;
  int   mismatch_count;
  bit   calm = 1'b0;   // no idling on either side while set
  int   stall_left = 0;

  bcf_in_if  in_if();
  bcf_out_if out_if();

  bezier_curve_flattener_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  bcf_vertex_checker vertex_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_if),
    .out_ch         (out_if),
    .open_vertices  (open_vertices),
    .mismatch_count (mismatch_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0:       return coord_t'(int'($urandom_range(4095)) - 2048);
      1:       return $urandom_range(1) ? COORD_MAX : COORD_MIN;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Keep most counts small
  function automatic seg_t rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 70) return seg_t'($urandom_range(12));
    if (r < 92) return seg_t'($urandom_range(13, 40));
    return seg_t'($urandom_range(41, MAX_SEGMENTS));
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    c.kind = $urandom_range(1) ? KIND_CUBIC : KIND_QUAD;
    foreach (c.pt[k]) c.pt[k] = rand_coord();
    c.n = rand_count();
    return c;
  endfunction

  function automatic curve_t curve_of(logic kind, coord_t sx, coord_t sy, coord_t c1x,
                                      coord_t c1y, coord_t c2x, coord_t c2y,
                                      coord_t ex, coord_t ey, seg_t n);
    curve_t c;
    c.kind  = kind;
    c.pt[0] = sx;  c.pt[1] = sy;
    c.pt[2] = c1x; c.pt[3] = c1y;
    c.pt[4] = c2x; c.pt[5] = c2y;
    c.pt[6] = ex;  c.pt[7] = ey;
    c.n     = n;
    return c;
  endfunction

  // Hold valid low for the gap, then present the curve until its transfer
  task automatic send_curve(input curve_t c, input int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.kind          <= c.kind;
    in_if.start_x       <= c.pt[0];
    in_if.start_y       <= c.pt[1];
    in_if.ctrl1_x       <= c.pt[2];
    in_if.ctrl1_y       <= c.pt[3];
    in_if.ctrl2_x       <= c.pt[4];
    in_if.ctrl2_y       <= c.pt[5];
    in_if.end_x         <= c.pt[6];
    in_if.end_y         <= c.pt[7];
    in_if.segment_count <= c.n;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Vertex receiver: random stalls, none in calm phases
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (calm) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      stall_left   <= pick_gap();
    end
  end

  initial begin
    curve_t directed_q[$];
    bit     quiet;
    in_if.valid         = 1'b0;
    in_if.kind          = KIND_QUAD;
    in_if.start_x       = '0;
    in_if.start_y       = '0;
    in_if.ctrl1_x       = '0;
    in_if.ctrl1_y       = '0;
    in_if.ctrl2_x       = '0;
    in_if.ctrl2_y       = '0;
    in_if.end_x         = '0;
    in_if.end_y         = '0;
    in_if.segment_count = '0;

    // Zero count, single segment, full count, extreme and bit-pattern coordinates
    directed_q.push_back(curve_of(KIND_QUAD, 0, 0, 0, 0, 0, 0, COORD_MAX, COORD_MIN, 0));
    directed_q.push_back(curve_of(KIND_CUBIC, 5, -5, 7, -7, 9, -9, COORD_MIN, COORD_MAX, 0));
    directed_q.push_back(curve_of(KIND_QUAD, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                                  COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1));
    directed_q.push_back(curve_of(KIND_CUBIC, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                  COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1));
    directed_q.push_back(curve_of(KIND_QUAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 63));
    directed_q.push_back(curve_of(KIND_CUBIC, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                  COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 63));
    directed_q.push_back(curve_of(KIND_CUBIC, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                  COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 63));
    directed_q.push_back(curve_of(KIND_QUAD, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, 63));
    // Quadratic with a wild second control point, which must be ignored
    directed_q.push_back(curve_of(KIND_QUAD, 256, 512, 1024, -2048, COORD_MIN, COORD_MAX,
                                  -256, 4096, 2));
    directed_q.push_back(curve_of(KIND_CUBIC, 0, 0, 0, 0, 0, 0, 0, 0, 3));
    directed_q.push_back(curve_of(KIND_QUAD, -1, 1, 1, -1, -1, 1, 1, -1, 7));
    directed_q.push_back(curve_of(KIND_CUBIC, -100, 300, 2000, -4000, -7000, 9000,
                                  12345, -54321, 32));
    directed_q.push_back(curve_of(KIND_CUBIC, -1, -1, -1, -1, -1, -1, -1, -1, 2));
    directed_q.push_back(curve_of(KIND_QUAD, coord_t'(24'h555555), coord_t'(24'hAAAAAA),
                                  coord_t'(24'hAAAAAA), coord_t'(24'h555555),
                                  coord_t'(24'h555555), coord_t'(24'hAAAAAA),
                                  coord_t'(24'h555555), coord_t'(24'hAAAAAA), 5));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[k]) send_curve(directed_q[k], 0);

    // Random curves, with every fourth stretch free of idling
    for (int k = 0; k < RANDOM_CURVES; k++) begin
      quiet = ((k / 40) % 4 == 3);
      calm <= quiet;
      send_curve(random_curve(), quiet ? 0 : pick_gap());
    end
    in_if.valid <= 1'b0;

    // Let the count from the last transfer settle, then drain
    @(posedge clk);
    while (open_vertices != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hang guard, well beyond a run with every vertex stalled at length
  initial begin
    #150000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/bcf_pkg.sv
src/bcf_if.sv
src/bcf_div.sv
src/bcf_lerp.sv
src/bezier_curve_flattener_unit.sv
sim/bcf_vertex_checker.sv
sim/tb_bezier_curve_flattener_unit.sv
